FILE: rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CAP_W    = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1023);

  // Action codes; anything else behaves as no action
  localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_REAR  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_REAR  = 3'd4;

  // Reported for both ends while the deque is empty
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
  } out_item_t;

  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
  } cdq_status_t;

endpackage

FILE: rtl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/cdq_ptr.sv
`timescale 1ns / 1ps

module cdq_ptr #(
  parameter int unsigned RING_SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [cdq_pkg::ACTION_W-1:0]  action_i,
  input  logic                          cfg_we_i,
  input  logic [cdq_pkg::CAP_W-1:0]     cfg_cap_i,
  output logic                          wr_en_o,
  output logic [$clog2(RING_SLOTS)-1:0] wr_addr_o,
  output logic [$clog2(RING_SLOTS)-1:0] front_addr_o,
  output logic [$clog2(RING_SLOTS)-1:0] rear_addr_o,
  output cdq_pkg::cdq_status_t          status_o
);

  import cdq_pkg::*;

  localparam int unsigned PW   = $clog2(RING_SLOTS);
  localparam int unsigned CMPW = (PW > CAP_W) ? PW : CAP_W;
  localparam int unsigned MAX_LAST = RING_SLOTS - 1;
  localparam logic [PW-1:0] LAST_RST =
    PW'((MAX_LAST < 1023) ? MAX_LAST : 1023);

  // last_q is the highest slot index: the effective capacity
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] last_q, last_d;
  logic          ok_q, ok_d;

  logic [CMPW-1:0] cap_ext;
  logic            empty_cur;
  logic            full_cur;
  logic [PW-1:0]   tail_next;

  function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p, logic [PW-1:0] last);
    ring_next = (p == last) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(logic [PW-1:0] p, logic [PW-1:0] last);
    ring_prev = (p == '0) ? last : p - PW'(1);
  endfunction

  assign cap_ext   = CMPW'(cfg_cap_i);
  assign tail_next = ring_next(tail_q, last_q);
  assign empty_cur = (head_q == tail_q);
  assign full_cur  = (tail_next == head_q);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    last_d    = last_q;
    ok_d      = ok_q;
    wr_en_o   = 1'b0;
    wr_addr_o = head_q;
    if (cfg_we_i) begin
      head_d = '0;
      tail_d = '0;
      if (cap_ext == '0) begin
        last_d = PW'(1);
      end else if (cap_ext > CMPW'(MAX_LAST)) begin
        last_d = PW'(MAX_LAST);
      end else begin
        last_d = PW'(cap_ext);
      end
    end else if (step_i) begin
      ok_d = 1'b1;
      case (action_i)
        ACT_INS_FRONT: begin
          if (full_cur) begin
            ok_d = 1'b0;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = head_q;
            head_d    = ring_prev(head_q, last_q);
          end
        end
        ACT_INS_REAR: begin
          if (full_cur) begin
            ok_d = 1'b0;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = tail_next;
            tail_d    = tail_next;
          end
        end
        ACT_DEL_FRONT: begin
          if (empty_cur) begin
            ok_d = 1'b0;
          end else begin
            head_d = ring_next(head_q, last_q);
          end
        end
        ACT_DEL_REAR: begin
          if (empty_cur) begin
            ok_d = 1'b0;
          end else begin
            tail_d = ring_prev(tail_q, last_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      last_q <= LAST_RST;
      ok_q   <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      last_q <= last_d;
      ok_q   <= ok_d;
    end
  end

  assign front_addr_o   = ring_next(head_q, last_q);
  assign rear_addr_o    = tail_q;
  assign status_o.ok    = ok_q;
  assign status_o.empty = empty_cur;
  assign status_o.full  = full_cur;

endmodule

FILE: rtl/circular_deque_unit.sv
`timescale 1ns / 1ps

// Double-ended queue of 32-bit words held in a ring of capacity+1 slots in one
// RAM with a write port and two registered read ports. In the accept cycle the
// pointers move and an insert writes its word; the next cycle reads the first
// and last slots; the output state then presents the result, held until taken.
// Only one item is in flight, set by the RAM read latency after the pointer
// update. Writing capacity empties the deque; it is taken only between items
// and beats a simultaneous input.
module circular_deque_unit #(
  parameter int unsigned RING_SLOTS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  cdq_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output cdq_pkg::out_item_t        out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_data_i
);

  import cdq_pkg::*;

  localparam int unsigned PW = $clog2(RING_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic              step;
  logic              cfg_we;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [PW-1:0]     front_addr;
  logic [PW-1:0]     rear_addr;
  logic [DATA_W-1:0] front_rd;
  logic [DATA_W-1:0] rear_rd;
  cdq_status_t       status;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE) | cfg_valid_i;
  assign step        = in_valid_i & ~in_stall_o;

  cdq_ptr #(
    .RING_SLOTS(RING_SLOTS)
  ) u_ptr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (in_item_i.action),
    .cfg_we_i    (cfg_we),
    .cfg_cap_i   (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .front_addr_o(front_addr),
    .rear_addr_o (rear_addr),
    .status_o    (status)
  );

  cdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RING_SLOTS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (in_item_i.value),
    .re_i     (state_q == ST_RD),
    .raddr_a_i(front_addr),
    .raddr_b_i(rear_addr),
    .rdata_a_o(front_rd),
    .rdata_b_o(rear_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (step) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pointers and read data stay put while the result waits
  assign out_valid_o            = (state_q == ST_OUT);
  assign out_item_o.ok          = status.ok;
  assign out_item_o.is_empty    = status.empty;
  assign out_item_o.is_full     = status.full;
  assign out_item_o.front_value = status.empty ? EMPTY_WORD : front_rd;
  assign out_item_o.rear_value  = status.empty ? EMPTY_WORD : rear_rd;

endmodule
